@@ src/tss_pkg.sv @@
package tss_pkg;

    // one span request: three vertices and the row asked for
    typedef struct packed {
        logic [8:0] vertex_a_x;
        logic [7:0] vertex_a_y;
        logic [8:0] vertex_b_x;
        logic [7:0] vertex_b_y;
        logic [8:0] vertex_c_x;
        logic [7:0] vertex_c_y;
        logic [7:0] row_index;
    } t_span_req;

    // one span result
    typedef struct packed {
        logic        row_covered;
        logic [8:0]  span_left;
        logic [8:0]  span_right;
        logic [31:0] span_color;
    } t_span_rsp;

    // fill color register write data
    typedef logic [31:0] t_cfg_data;

endpackage

@@ src/tss_stream_if.sv @@
interface tss_stream_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/triangle_scanline_span_unit.sv @@
// triangle scanline span unit
//
// i_req (sink) takes one triangle (three vertices) plus a row number per
// transfer; o_rsp (source) gives one result per request, in order: a covered
// flag, the inclusive left and right columns on that row (both 0 when not
// covered) and the fill color. i_cfg takes writes of the fill color; it is
// always ready and should only be written while no request is in flight.
//
// six register stages: edge setup, numerator, three divide stages and
// output. throughput: one request per cycle while o_rsp does not stall.
// each edge has its own pipelined restoring divider for the rounded
// crossing column, three quotient bits per stage.
//
// reset clears all stage valid bits and the fill color; no results pending.
// when o_rsp stalls, the output holds and stages fill up behind it; empty
// stages keep taking requests, i_req.ready drops only once every stage holds
// a request.
module triangle_scanline_span_unit
    import tss_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tss_stream_if.sink   i_req,
    tss_stream_if.sink   i_cfg,
    tss_stream_if.source o_rsp
);

    localparam int          NSTG   = 6;
    localparam logic [12:0] W_MAX  = 13'(SCREEN_WIDTH - 1);
    localparam logic [12:0] H_ROWS = 13'(SCREEN_HEIGHT);

    // per-edge working record, carried through stages 0..4
    typedef struct packed {
        logic        hit;   // row lies within the edge's y range
        logic        flat;  // horizontal edge
        logic [8:0]  xa;    // column at the upper end
        logic [8:0]  xb;    // column at the lower end
        logic [7:0]  d;     // y extent
        logic [7:0]  dlo;   // row - upper y
        logic [7:0]  dhi;   // lower y - row
        logic [17:0] rem;   // divider remainder
        logic [8:0]  dvs;   // divider divisor, 2*d
        logic [8:0]  quo;   // rounded crossing column
    } t_edge;

    typedef struct packed {
        logic        row_ok;
        t_edge [2:0] edges;
    } t_stage;

    typedef struct packed {
        logic       row_covered;
        logic [8:0] span_left;
        logic [8:0] span_right;
    } t_span_out;

    // sort one edge by y and work out its distances to the row
    function automatic t_edge edge_setup(input logic [8:0] px, input logic [7:0] py,
                                         input logic [8:0] qx, input logic [7:0] qy,
                                         input logic [7:0] r);
        t_edge      e;
        logic [8:0] ux, lx;
        logic [7:0] uy, ly;
        if (py > qy) begin
            ux = qx; uy = qy; lx = px; ly = py;
        end else begin
            ux = px; uy = py; lx = qx; ly = qy;
        end
        e      = '0;
        e.hit  = (r >= uy) && (r <= ly);
        e.flat = (uy == ly);
        e.xa   = ux;
        e.xb   = lx;
        e.d    = ly - uy;
        e.dlo  = r - uy;
        e.dhi  = ly - r;
        return e;
    endfunction

    // three restoring divide steps, quotient bits top..top-2
    function automatic t_edge div_step3(input t_edge e, input int top);
        t_edge       o;
        logic [17:0] sh;
        o = e;
        for (int j = 0; j < 3; j++) begin
            sh = 18'(o.dvs) << (top - j);
            if (o.rem >= sh) begin
                o.rem = o.rem - sh;
                o.quo[4'(top - j)] = 1'b1;
            end
        end
        return o;
    endfunction

    logic [31:0] r_fill_color;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;
    t_stage     r_pipe [NSTG-1];
    t_stage     n_pipe [NSTG-1];
    t_span_out  r_out;
    t_span_out  n_out;

    // stage k loads when it is empty or its contents move on
    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || o_rsp.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_req.ready = adv[0];
    assign i_cfg.ready = 1'b1;

    // stage 0: edge sort and row distances
    always_comb begin
        n_pipe[0].row_ok   = (13'(i_req.data.row_index) < H_ROWS);
        n_pipe[0].edges[0] = edge_setup(i_req.data.vertex_a_x, i_req.data.vertex_a_y,
                                        i_req.data.vertex_b_x, i_req.data.vertex_b_y,
                                        i_req.data.row_index);
        n_pipe[0].edges[1] = edge_setup(i_req.data.vertex_b_x, i_req.data.vertex_b_y,
                                        i_req.data.vertex_c_x, i_req.data.vertex_c_y,
                                        i_req.data.row_index);
        n_pipe[0].edges[2] = edge_setup(i_req.data.vertex_c_x, i_req.data.vertex_c_y,
                                        i_req.data.vertex_a_x, i_req.data.vertex_a_y,
                                        i_req.data.row_index);
    end

    // stage 1: interpolation numerator, rounded dividend 2*num + d
    always_comb begin
        logic [16:0] num;
        n_pipe[1] = r_pipe[0];
        for (int i = 0; i < 3; i++) begin
            num = 17'(r_pipe[0].edges[i].xa) * 17'(r_pipe[0].edges[i].dhi)
                + 17'(r_pipe[0].edges[i].xb) * 17'(r_pipe[0].edges[i].dlo);
            n_pipe[1].edges[i].rem = {num, 1'b0} + 18'(r_pipe[0].edges[i].d);
            n_pipe[1].edges[i].dvs = {r_pipe[0].edges[i].d, 1'b0};
            n_pipe[1].edges[i].quo = '0;
        end
    end

    // stages 2..4: quotient bits 8..6, 5..3, 2..0
    for (genvar s = 2; s < NSTG - 1; s++) begin : g_div
        always_comb begin
            n_pipe[s] = r_pipe[s-1];
            for (int i = 0; i < 3; i++) begin
                n_pipe[s].edges[i] = div_step3(r_pipe[s-1].edges[i], 8 - 3 * (s - 2));
            end
        end
    end

    // output stage: extreme crossings, screen clamp
    always_comb begin
        logic       any;
        logic [8:0] lo, hi, x0, x1;
        any = 1'b0;
        lo  = '0;
        hi  = '0;
        for (int i = 0; i < 3; i++) begin
            if (r_pipe[NSTG-2].edges[i].flat) begin
                x0 = (r_pipe[NSTG-2].edges[i].xa < r_pipe[NSTG-2].edges[i].xb)
                   ? r_pipe[NSTG-2].edges[i].xa : r_pipe[NSTG-2].edges[i].xb;
                x1 = (r_pipe[NSTG-2].edges[i].xa < r_pipe[NSTG-2].edges[i].xb)
                   ? r_pipe[NSTG-2].edges[i].xb : r_pipe[NSTG-2].edges[i].xa;
            end else begin
                x0 = r_pipe[NSTG-2].edges[i].quo;
                x1 = r_pipe[NSTG-2].edges[i].quo;
            end
            if (r_pipe[NSTG-2].edges[i].hit) begin
                if (!any || x0 < lo) lo = x0;
                if (!any || x1 > hi) hi = x1;
                any = 1'b1;
            end
        end
        n_out.row_covered = any && r_pipe[NSTG-2].row_ok && (13'(lo) <= W_MAX);
        if (n_out.row_covered) begin
            n_out.span_left  = lo;
            n_out.span_right = (13'(hi) > W_MAX) ? W_MAX[8:0] : hi;
        end else begin
            n_out.span_left  = '0;
            n_out.span_right = '0;
        end
    end

    // valid bits and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_fill_color <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_req.valid;
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) r_vld[k] <= r_vld[k-1];
            end
            if (i_cfg.valid) r_fill_color <= i_cfg.data;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG - 1; k++) begin
            if (adv[k]) r_pipe[k] <= n_pipe[k];
        end
        if (adv[NSTG-1]) r_out <= n_out;
    end

    assign o_rsp.valid            = r_vld[NSTG-1];
    assign o_rsp.data.row_covered = r_out.row_covered;
    assign o_rsp.data.span_left   = r_out.span_left;
    assign o_rsp.data.span_right  = r_out.span_right;
    assign o_rsp.data.span_color  = r_fill_color;

    // covered span is ordered left to right
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.row_covered) |->
            (o_rsp.data.span_left <= o_rsp.data.span_right))
        else $error("span ends out of order");

    // uncovered rows report a zero span
    a_span_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.data.row_covered) |->
            (o_rsp.data.span_left == '0 && o_rsp.data.span_right == '0))
        else $error("uncovered row with nonzero span");

    // covered span stays on screen
    a_span_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.row_covered) |->
            (13'(o_rsp.data.span_right) <= W_MAX))
        else $error("span right beyond screen");

    // a full pipeline behind a stalled output takes no new request
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !o_rsp.ready) |-> !i_req.ready)
        else $error("request taken while pipeline full");

    // a stalled output keeps its result for the next edge
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule
